[hw/rtl/hrm_pkg.sv]
`default_nettype none

package hrm_pkg;

  // Field widths of one transaction
  localparam int CHUNK_W  = 4;
  localparam int VAR_W    = 4;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  // Chunk indices are 4 bits wide, so no more than 16 chunks can be reported
  localparam int MAX_REPORT = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_LINK  = 2'd2;
  localparam logic [OP_W-1:0] OP_SWEEP = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NALLOC = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;    // run a single-result operation on the incoming transaction
    logic seed;    // load marks from the valid roots
    logic expand;  // one round of frontier expansion
    logic emit;    // load the next sweep result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic round_last;  // final expansion round
    logic emit_last;   // result being emitted is the last chunk
    logic heap_empty;  // no chunk allocated
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/hrm_ctrl.sv]
`default_nettype none

module hrm_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [hrm_pkg::OP_W-1:0] in_op_i,
  input  wire hrm_pkg::sts_t          sts_i,
  output logic                        in_ready_o,
  output hrm_pkg::cmd_t               cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEED   = 2'd1;
  localparam logic [1:0] S_EXPAND = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  // Take a transaction only when idle and the output register can be refilled
  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o        = '0;
    cmd_o.exec   = accept && (in_op_i != hrm_pkg::OP_SWEEP);
    cmd_o.seed   = (state_q == S_SEED);
    cmd_o.expand = (state_q == S_EXPAND);
    cmd_o.emit   = (state_q == S_EMIT) && sts_i.out_free;
  end

  // Advance through seed, expansion rounds and result emission
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (in_op_i == hrm_pkg::OP_SWEEP)) state_d = S_SEED;
      end
      S_SEED: begin
        state_d = S_EXPAND;
      end
      S_EXPAND: begin
        if (sts_i.round_last) state_d = sts_i.heap_empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hrm_dp.sv]
`default_nettype none

module hrm_dp #(
  parameter int HEAP_CHUNKS = 16,
  parameter int ROOT_VARS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hrm_pkg::cmd_t                 cmd_i,
  input  wire logic [hrm_pkg::OP_W-1:0]      op_i,
  input  wire logic [hrm_pkg::VAR_W-1:0]     var_index_i,
  input  wire logic                          has_chunk_i,
  input  wire logic [hrm_pkg::CHUNK_W-1:0]   chunk_a_i,
  input  wire logic [hrm_pkg::CHUNK_W-1:0]   chunk_b_i,
  input  wire logic                          out_ready_i,
  output hrm_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  output logic [hrm_pkg::CHUNK_W-1:0]        out_chunk_index_o,
  output logic                               out_reachable_o,
  output logic [hrm_pkg::STATUS_W-1:0]       out_status_o,
  output logic                               out_last_o
);

  localparam int CAP   = (HEAP_CHUNKS < hrm_pkg::MAX_REPORT) ? HEAP_CHUNKS
                                                             : hrm_pkg::MAX_REPORT;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int CMP_W = hrm_pkg::CHUNK_W + 1;
  localparam int RV    = (ROOT_VARS < (1 << hrm_pkg::VAR_W)) ? ROOT_VARS
                                                             : (1 << hrm_pkg::VAR_W);
  localparam int RV_W  = (RV > 1) ? $clog2(RV) : 1;

  logic [CNT_W-1:0]            count_q;
  logic [CAP-1:0]              link_q [CAP];
  logic [CAP-1:0]              mark_q;
  logic [RV-1:0]               root_vld_q;
  logic [hrm_pkg::CHUNK_W-1:0] root_tgt_q [RV];
  logic [IDX_W-1:0]            rnd_q;
  logic [IDX_W-1:0]            emit_q;

  logic                          out_valid_q;
  logic [hrm_pkg::CHUNK_W-1:0]   out_idx_q, out_idx_d;
  logic                          out_reach_q, out_reach_d;
  logic [hrm_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic                          out_last_q, out_last_d;

  logic           full, a_ok, b_ok, var_ok, load;
  logic           do_alloc, do_set, do_link;
  logic [CAP-1:0] seed_mark, grow_mark;

  // Decode the single-result operations
  assign full     = (count_q == CNT_W'(CAP));
  assign a_ok     = (CMP_W'(chunk_a_i) < CMP_W'(count_q));
  assign b_ok     = (CMP_W'(chunk_b_i) < CMP_W'(count_q));
  assign var_ok   = (int'(var_index_i) < RV);
  assign do_alloc = cmd_i.exec && (op_i == hrm_pkg::OP_ALLOC) && !full;
  assign do_set   = cmd_i.exec && (op_i == hrm_pkg::OP_SET) && var_ok &&
                    (!has_chunk_i || a_ok);
  assign do_link  = cmd_i.exec && (op_i == hrm_pkg::OP_LINK) && a_ok && b_ok;

  // Mark the targets of valid roots that point into the heap
  always_comb begin
    seed_mark = '0;
    for (int r = 0; r < RV; r++) begin
      if (root_vld_q[r] && (CMP_W'(root_tgt_q[r]) < CMP_W'(count_q))) begin
        seed_mark[root_tgt_q[r][IDX_W-1:0]] = 1'b1;
      end
    end
  end

  // One round: add the links of every marked chunk
  always_comb begin
    grow_mark = mark_q;
    for (int i = 0; i < CAP; i++) begin
      if (mark_q[i] && (CNT_W'(i) < count_q)) grow_mark = grow_mark | link_q[i];
    end
  end

  // Heap size, links and marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mark_q  <= '0;
      for (int i = 0; i < CAP; i++) link_q[i] <= '0;
    end else begin
      if (do_alloc) begin
        count_q                     <= count_q + CNT_W'(1);
        link_q[count_q[IDX_W-1:0]]  <= '0;
        mark_q[count_q[IDX_W-1:0]]  <= 1'b0;
      end
      if (do_link) link_q[chunk_a_i[IDX_W-1:0]][chunk_b_i[IDX_W-1:0]] <= 1'b1;
      if (cmd_i.seed) mark_q <= seed_mark;
      else if (cmd_i.expand) mark_q <= grow_mark;
    end
  end

  // Root variables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q <= '0;
    end else if (do_set) begin
      root_vld_q[var_index_i[RV_W-1:0]] <= has_chunk_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_set && has_chunk_i) root_tgt_q[var_index_i[RV_W-1:0]] <= chunk_a_i;
  end

  // Expansion round and emission counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      emit_q <= '0;
    end else begin
      if (cmd_i.seed) begin
        rnd_q  <= '0;
        emit_q <= '0;
      end else begin
        if (cmd_i.expand) rnd_q <= rnd_q + IDX_W'(1);
        if (cmd_i.emit) emit_q <= emit_q + IDX_W'(1);
      end
    end
  end

  // Select the next result
  always_comb begin
    out_idx_d    = '0;
    out_reach_d  = 1'b0;
    out_status_d = hrm_pkg::ST_OK;
    out_last_d   = 1'b1;
    if (cmd_i.emit) begin
      out_idx_d   = hrm_pkg::CHUNK_W'(emit_q);
      out_reach_d = mark_q[emit_q];
      out_last_d  = sts_o.emit_last;
    end else begin
      case (op_i)
        hrm_pkg::OP_ALLOC: begin
          if (full) out_status_d = hrm_pkg::ST_FULL;
          else out_idx_d = hrm_pkg::CHUNK_W'(count_q);
        end
        hrm_pkg::OP_SET: begin
          if (has_chunk_i && !a_ok) out_status_d = hrm_pkg::ST_NALLOC;
        end
        hrm_pkg::OP_LINK: begin
          if (!(a_ok && b_ok)) out_status_d = hrm_pkg::ST_NALLOC;
        end
        default: begin
          out_status_d = hrm_pkg::ST_OK;
        end
      endcase
    end
  end

  // Output register: load a result, drop it once taken
  assign load = cmd_i.exec || cmd_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q    <= out_idx_d;
      out_reach_q  <= out_reach_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.round_last = (rnd_q == IDX_W'(CAP - 1));
    sts_o.emit_last  = ((CNT_W'(emit_q) + CNT_W'(1)) == count_q);
    sts_o.heap_empty = (count_q == '0);
  end

  assign out_valid_o       = out_valid_q;
  assign out_chunk_index_o = out_idx_q;
  assign out_reachable_o   = out_reach_q;
  assign out_status_o      = out_status_q;
  assign out_last_o        = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/heap_reachability_marker_unit.sv]
// Heap reachability marker: a small heap of chunks with a link matrix and a
// set of root variables, answering mark-and-sweep reachability queries.
// Input channel s_axis: one transaction per operation, kind in tuser
// (allocate, set root, add link, sweep), operands in tdata.
// Output channel m_axis: result transactions; tlast marks the final result
// of one input transaction, tuser carries the status code.
// Allocate, set root and add link give one result, valid the cycle after
// acceptance; the next transaction is taken in that same cycle if the
// output register is free or being drained.
// A sweep runs a seed step, then C expansion rounds, one round per cycle on
// the link-matrix OR tree (C = min(HEAP_CHUNKS, 16)), then one result per
// allocated chunk per cycle while the output register is free. No input is
// taken during a sweep.
// When m_axis_tready is low the pending result holds in the output register
// and s_axis_tready stays low until it is taken.
// Reset empties the heap, clears all links, roots and marks; no clearing
// pass is needed.
`default_nettype none

module heap_reachability_marker_unit #(
  parameter int HEAP_CHUNKS = 16,
  parameter int ROOT_VARS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] var_index, [4] has_chunk, [8:5] chunk_a, [12:9] chunk_b, [15:13] zero
  input  wire logic [15:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] chunk_index, [4] reachable, [7:5] zero
  output logic [7:0]       m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  hrm_pkg::cmd_t               cmd;
  hrm_pkg::sts_t               sts;
  logic [hrm_pkg::CHUNK_W-1:0] out_idx;
  logic                        out_reach;

  hrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  hrm_dp #(
    .HEAP_CHUNKS (HEAP_CHUNKS),
    .ROOT_VARS   (ROOT_VARS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .op_i              (s_axis_tuser),
    .var_index_i       (s_axis_tdata[3:0]),
    .has_chunk_i       (s_axis_tdata[4]),
    .chunk_a_i         (s_axis_tdata[8:5]),
    .chunk_b_i         (s_axis_tdata[12:9]),
    .out_ready_i       (m_axis_tready),
    .sts_o             (sts),
    .out_valid_o       (m_axis_tvalid),
    .out_chunk_index_o (out_idx),
    .out_reachable_o   (out_reach),
    .out_status_o      (m_axis_tuser),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_reach, out_idx};

  // A stalled result blocks new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while a result is stalled");

  // Single-result operations answer in the next cycle with tlast
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != hrm_pkg::OP_SWEEP))
    |=> (m_axis_tvalid && m_axis_tlast))
    else $error("single-result operation did not answer");

  // A sweep holds off input while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == hrm_pkg::OP_SWEEP))
    |=> !s_axis_tready)
    else $error("input accepted during a sweep");

  // A reachable verdict only comes with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tuser == hrm_pkg::ST_OK))
    else $error("reachable result carries an error status");

endmodule

`default_nettype wire
